[rtl/core/ilid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and constants for the indexed list
// Operation and status codes, field widths and the per-cell control word.
// ----------------------------------------------------------------------------
package ilid_pkg;

   localparam int unsigned DATA_W       = 32;
   localparam int unsigned POS_W        = 16;
   localparam int unsigned OCC_W        = 5;
   localparam int unsigned CAPACITY_DEF = 16;

   typedef enum logic [1:0] {
      OP_GET    = 2'd0,
      OP_INSERT = 2'd1,
      OP_APPEND = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic             ins;   // place a value at pos, shift later cells up
      logic             del;   // drop entry at pos, shift later cells down
      logic [POS_W-1:0] pos;
   } cell_ctrl_type;

endpackage

[rtl/core/ilid_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_cell: one list slot
// Holds one entry; loads, takes its left or right neighbor, or holds.
// ----------------------------------------------------------------------------
module ilid_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                                  clock,
   input  ilid_pkg::cell_ctrl_type               ctrl,
   input  logic signed [ilid_pkg::DATA_W-1:0]    in_value,
   input  logic signed [ilid_pkg::DATA_W-1:0]    left_value,
   input  logic signed [ilid_pkg::DATA_W-1:0]    right_value,
   output logic signed [ilid_pkg::DATA_W-1:0]    cell_value,
   output logic signed [ilid_pkg::DATA_W-1:0]    read_value
);

   localparam logic [ilid_pkg::POS_W-1:0] MY_POS = ilid_pkg::POS_W'(INDEX);

   logic                                 at_pos;
   logic                                 above_pos;
   logic signed [ilid_pkg::DATA_W-1:0]   value_ff;
   logic signed [ilid_pkg::DATA_W-1:0]   value_in;

   assign at_pos    = (ctrl.pos == MY_POS);
   assign above_pos = (ctrl.pos < MY_POS);

   always_comb begin
      value_in = value_ff;
      if (ctrl.ins) begin
         if (at_pos) begin
            value_in = in_value;
         end else if (above_pos) begin
            value_in = left_value;
         end
      end else if (ctrl.del) begin
         if (at_pos || above_pos) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;
   // masked so the top can OR all cells together
   assign read_value = at_pos ? value_ff : '0;

endmodule

[rtl/core/indexed_list_insert_delete.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: position-addressed list of signed words
// Row of CAPACITY cells with an occupancy counter and a registered result.
// ----------------------------------------------------------------------------
// Takes one operation per clock unless a result waits on rsp_ready, and
// returns one result per operation in the next cycle. Each cell holds one
// entry; insert and delete move every later entry to its neighbor cell in that
// same cycle, so the next operation can follow at once. Get reads the cell at
// the position through a masked OR across the row. The result sits in an
// output register, and a new request is taken whenever that register is empty
// or being drained in the same cycle. Insert beyond the count, and get or
// delete at or beyond it, report out of range; insert or append with the list
// full is dropped and reports full. The range check on insert comes before the
// full check. Occupancy reports the low five bits of the count.
module indexed_list_insert_delete #(
   parameter int unsigned CAPACITY = ilid_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_op,
   input  logic [ilid_pkg::POS_W-1:0]            req_position,
   input  logic signed [ilid_pkg::DATA_W-1:0]    req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [ilid_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [1:0]                            rsp_status,
   output logic [ilid_pkg::OCC_W-1:0]            rsp_occupancy
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned DW    = ilid_pkg::DATA_W;
   localparam int unsigned PW    = ilid_pkg::POS_W;
   localparam int unsigned OW    = ilid_pkg::OCC_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   // request side
   logic                    accept;
   ilid_pkg::op_type        op;
   logic [PW-1:0]           count_ext;
   logic                    full;

   // list state
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   ilid_pkg::cell_ctrl_type ctrl;
   logic signed [DW-1:0]    cell_value [CAPACITY];
   logic signed [DW-1:0]    cell_read  [CAPACITY];
   logic signed [DW-1:0]    row_read;

   // result register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [DW-1:0]    read_value_ff;
   logic signed [DW-1:0]    read_value_in;
   ilid_pkg::status_type    status_ff;
   ilid_pkg::status_type    status_in;
   logic [OW-1:0]           occ_ff;
   logic [OW-1:0]           occ_in;
   logic [CNT_W+OW-1:0]     count_wide;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign op        = ilid_pkg::op_type'(req_op);
   assign count_ext = PW'(count_ff);
   assign full      = (count_ff == CNT_FULL);

   // decode: pick the cell command, new count and result fields
   always_comb begin
      ctrl.ins      = 1'b0;
      ctrl.del      = 1'b0;
      ctrl.pos      = req_position;
      count_in      = count_ff;
      read_value_in = '0;
      status_in     = ilid_pkg::ST_DONE;
      case (op)
         ilid_pkg::OP_GET: begin
            if (req_position < count_ext) begin
               read_value_in = row_read;
            end else begin
               read_value_in = -1;
               status_in     = ilid_pkg::ST_RANGE;
            end
         end
         ilid_pkg::OP_INSERT: begin
            if (req_position > count_ext) begin
               status_in = ilid_pkg::ST_RANGE;
            end else if (full) begin
               status_in = ilid_pkg::ST_FULL;
            end else begin
               ctrl.ins = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ilid_pkg::OP_APPEND: begin
            ctrl.pos = count_ext;
            if (full) begin
               status_in = ilid_pkg::ST_FULL;
            end else begin
               ctrl.ins = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ilid_pkg::OP_DELETE: begin
            if (req_position >= count_ext) begin
               status_in = ilid_pkg::ST_RANGE;
            end else begin
               ctrl.del = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status_in = ilid_pkg::ST_DONE;
         end
      endcase
   end

   // row of cells, each wired to its two neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DW-1:0] left_value;
      logic signed [DW-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[i+1];
      end

      ilid_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .in_value    (req_value),
         .left_value  (left_value),
         .right_value (right_value),
         .cell_value  (cell_value[i]),
         .read_value  (cell_read[i])
      );
   end

   // at most one cell drives a nonzero read
   always_comb begin
      row_read = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         row_read = row_read | cell_read[i];
      end
   end

   assign count_wide   = {{OW{1'b0}}, count_in};
   assign occ_in       = count_wide[OW-1:0];
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff <= read_value_in;
         status_ff     <= status_in;
         occ_ff        <= occ_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_occupancy  = occ_ff;

   // count never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("count above capacity");

   // a transfer always lands in the result register
   a_accept_valid: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   // append into a full list is dropped
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      accept && op == ilid_pkg::OP_APPEND && full
      |=> status_ff == ilid_pkg::ST_FULL && $stable(count_ff))
      else $error("append into full list not dropped");

   // out-of-range get reads all ones
   a_get_range: assert property (@(posedge clock) disable iff (reset)
      accept && op == ilid_pkg::OP_GET && req_position >= count_ext
      |=> read_value_ff == -1 && status_ff == ilid_pkg::ST_RANGE)
      else $error("out-of-range get result wrong");

   // get never changes the list
   a_get_hold: assert property (@(posedge clock) disable iff (reset)
      accept && op == ilid_pkg::OP_GET |=> $stable(count_ff))
      else $error("get changed the count");

endmodule
